@@ rtl/max_priority_queue_macros.svh @@
// Assertion macros for the max priority queue.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef MAX_PRIORITY_QUEUE_MACROS_SVH
`define MAX_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define MPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mpq_pkg.sv @@
// Shared types and constants of the max priority queue.
// No dependencies.
`timescale 1ns / 1ps
package mpq_pkg;
    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int IDX_W    = SLOT_W + 1;
    localparam int NODES    = 2 * CAPACITY;
    localparam int CNT_W    = SLOT_W + 1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // One tree node: the winning entry of its subtree.
    typedef struct packed {
        logic               valid;
        logic signed [31:0] key;
        logic [15:0]        tag;
        logic [31:0]        stamp;
        logic [SLOT_W-1:0]  slot;
    } node_t;

    localparam int NODE_W = $bits(node_t);
endpackage

@@ rtl/mpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

@@ rtl/mpq_winner.sv @@
// Match unit of the tournament tree: picks the larger key, older entry on a tie.
// Depends on mpq_pkg.
`timescale 1ns / 1ps
module mpq_winner (
    input  mpq_pkg::node_t a,
    input  mpq_pkg::node_t b,
    input  logic [31:0]    stamp_now,
    output mpq_pkg::node_t win
);
    import mpq_pkg::*;

    logic [31:0] age_a;
    logic [31:0] age_b;
    logic        a_wins;

    // Age is measured against the next stamp to hand out.
    assign age_a = stamp_now - a.stamp;
    assign age_b = stamp_now - b.stamp;

    always_comb begin
        a_wins = a.valid && (!b.valid || (a.key > b.key) ||
                 ((a.key == b.key) && (age_a > age_b)));
        win = a_wins ? a : b;
    end
endmodule

@@ rtl/max_priority_queue.sv @@
// Max priority queue over a tournament tree held in one node RAM, with its control.
// Depends on mpq_pkg, mpq_ram, mpq_winner and max_priority_queue_macros.svh.
`timescale 1ns / 1ps
// One beat in gives one beat out. An insert writes the new leaf and then updates the
// tree from leaf to root; a remove first reads the root to find the leaf to retire.
// The tree is updated one level per cycle through the single node RAM, whose sibling
// reads are issued one level ahead. Refused operations go straight to the output state.
// A result waits in the output register while the next beat is accepted. No clearing pass
// is needed after reset; subtree-valid bits live in flip-flops.
module max_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // key[31:0], tag[47:32]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_key[31:0], out_tag[47:32], occupancy[54:48], zero[55]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import mpq_pkg::*;
`include "max_priority_queue_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROOT = 2'd1;
    localparam logic [1:0] S_UP   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] n_reg, n_next;
    node_t            cur_reg, cur_next;
    logic [NODES-1:0] nvalid_reg, nvalid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      stamp_reg, stamp_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [31:0]      res_key_reg, res_key_next;
    logic [15:0]      res_tag_reg, res_tag_next;
    logic             m_valid_reg, m_valid_next;
    logic [55:0]      m_data_reg, m_data_next;
    logic [1:0]       m_user_reg, m_user_next;

    logic             s_fire;
    logic             full;
    logic [SLOT_W-1:0] free_slot;
    logic [IDX_W-1:0] leaf_idx;
    logic [IDX_W-1:0] parent_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    node_t            wr_node;
    logic [IDX_W-1:0] rd_addr;
    logic [NODE_W-1:0] rd_raw;
    node_t            rd_node;
    node_t            sib_node;
    node_t            par_node;
    node_t            new_leaf;

    assign s_fire = s_tvalid && s_tready;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign parent_idx = {1'b0, n_reg[IDX_W-1:1]};

    // Lowest free leaf.
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!nvalid_reg[CAPACITY + i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    mpq_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_node),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_node = node_t'(rd_raw);

    // Sibling validity comes from the flip-flops, not from the RAM.
    always_comb begin
        sib_node       = rd_node;
        sib_node.valid = nvalid_reg[{n_reg[IDX_W-1:1], ~n_reg[0]}];
    end

    mpq_winner u_winner (
        .a         (cur_reg),
        .b         (sib_node),
        .stamp_now (stamp_reg),
        .win       (par_node)
    );

    // Sequencer: root read for a remove, leaf update, then one tree level per cycle up to the root.
    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        cur_next        = cur_reg;
        nvalid_next     = nvalid_reg;
        count_next      = count_reg;
        stamp_next      = stamp_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_tag_next    = res_tag_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        leaf_idx        = {1'b1, free_slot};
        rd_addr         = {leaf_idx[IDX_W-1:1], ~leaf_idx[0]};
        s_tready        = (state_reg == S_IDLE);

        new_leaf.valid = 1'b1;
        new_leaf.key   = s_tdata[31:0];
        new_leaf.tag   = s_tdata[47:32];
        new_leaf.stamp = stamp_reg;
        new_leaf.slot  = free_slot;
        wr_node        = new_leaf;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    res_key_next = '0;
                    res_tag_next = '0;
                    if (s_tuser[0] == OP_INSERT) begin
                        if (full) begin
                            res_status_next = ST_FULL;
                            state_next      = S_FIN;
                        end else begin
                            res_status_next       = ST_OK;
                            wr_en                 = 1'b1;
                            wr_addr               = leaf_idx;
                            nvalid_next[leaf_idx] = 1'b1;
                            cur_next              = new_leaf;
                            n_next                = leaf_idx;
                            stamp_next            = stamp_reg + 32'd1;
                            count_next            = count_reg + CNT_W'(1);
                            state_next            = S_UP;
                        end
                    end else begin
                        rd_addr = IDX_W'(1);
                        if (count_reg == '0) begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_FIN;
                        end else begin
                            res_status_next = ST_OK;
                            count_next      = count_reg - CNT_W'(1);
                            state_next      = S_ROOT;
                        end
                    end
                end
            end
            S_ROOT: begin
                // Root holds the entry to remove; retire its leaf.
                leaf_idx              = {1'b1, rd_node.slot};
                rd_addr               = {leaf_idx[IDX_W-1:1], ~leaf_idx[0]};
                res_key_next          = rd_node.key;
                res_tag_next          = rd_node.tag;
                nvalid_next[leaf_idx] = 1'b0;
                cur_next              = rd_node;
                cur_next.valid        = 1'b0;
                n_next                = leaf_idx;
                state_next            = S_UP;
            end
            S_UP: begin
                wr_en                   = 1'b1;
                wr_addr                 = parent_idx;
                wr_node                 = par_node;
                nvalid_next[parent_idx] = par_node.valid;
                cur_next                = par_node;
                n_next                  = parent_idx;
                rd_addr                 = {parent_idx[IDX_W-1:1], ~parent_idx[0]};
                if (parent_idx == IDX_W'(1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, 7'(count_reg), res_tag_reg, res_key_reg};
                    m_user_next  = res_status_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            nvalid_reg  <= '0;
            count_reg   <= '0;
            stamp_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            nvalid_reg  <= nvalid_next;
            count_reg   <= count_next;
            stamp_reg   <= stamp_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg          <= n_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_tag_reg    <= res_tag_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // While idle, the root is occupied exactly when entries are held.
    `MPQ_ASSERT_NOW(a_root_matches_count, state_reg == S_IDLE, nvalid_reg[1] == (count_reg != '0), "root valid disagrees with count")
    `MPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `MPQ_ASSERT_NEXT(a_insert_counts, s_fire && (s_tuser[0] == OP_INSERT) && !full, count_reg == $past(count_reg) + CNT_W'(1), "insert did not count")
endmodule
